/* hw/rtl/frml_pkg.sv */
package frml_pkg;

    // Ring of interval samples
    localparam int WINDOW     = 20;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int INTERVAL_W = 16;
    localparam int SUM_W      = INTERVAL_W + $clog2(WINDOW + 1);

    // Rate arithmetic: fps_q8 = 1000 * 256 * count / sum
    localparam int FPS_SCALE_VAL = 256000;
    localparam int DIVIDEND_W    = $clog2(FPS_SCALE_VAL * WINDOW + 1);
    localparam int DIVCNT_W      = $clog2(DIVIDEND_W + 1);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int FPS_W   = 23;
    localparam int DELAY_W = 10;
    localparam int MAXFPS_W = 10;

    localparam logic [FPS_W-1:0]      FPS_WHEN_IDLE = FPS_W'(170666);
    localparam logic [FPS_W-1:0]      FPS_MAX       = {FPS_W{1'b1}};
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX  = {INTERVAL_W{1'b1}};
    localparam logic [MAXFPS_W-1:0]   MAXFPS_RESET  = MAXFPS_W'(60);
    localparam int                    MS_PER_SEC    = 1000;

    // Register indexes on the configuration port
    localparam logic REG_MAX_FPS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIVP,
        ST_DIVF,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/frame_rate_meter_limiter_unit.sv */
// Frame rate meter and limiter.
// Input stream: one transfer per finished frame, carrying the frame start
// time and the current time in milliseconds. Output stream: one transfer per
// input with the frame rate averaged over the last 20 frame intervals
// (unsigned Q.8) and the number of milliseconds to wait so the rate stays at
// the max_fps ceiling. max_fps is written over the APB port at address 0.
// Sequence: the old ring entry is read when the input transfer is taken, the
// new interval is written and the running sum updated in ST_UPD, then one
// shared restoring divider runs twice at one quotient bit a cycle (period
// 1000/max_fps, then rate), and the output register is loaded last. One item
// is in work at a time.
// The next input is taken while a finished result still waits in the output
// register; if the receiver stalls, that item finishes and then waits until
// the output register frees up.
// Reset clears the fill count, slot pointer, sum and previous time and sets
// max_fps to 60. Ring entries are used only after they have been written.
module frame_rate_meter_limiter_unit
    import frml_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] frame_start_ms, [63:32] now_ms
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [22:0] fps_q8, [32:23] delay_ms, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;

    logic [MAXFPS_W-1:0]   max_fps_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [TIME_W-1:0]     prev_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [TIME_W-1:0]     duration_reg;
    logic [DELAY_W-1:0]    period_reg;

    logic [SUM_W-1:0]      rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [SUM_W-1:0]      dsr_reg;
    logic [DIVCNT_W-1:0]   cnt_reg;

    logic                  m_tvalid_reg;
    logic [39:0]           m_tdata_reg;

    logic [TIME_W-1:0]     in_start;
    logic [TIME_W-1:0]     in_now;
    logic [TIME_W-1:0]     in_diff;
    logic [INTERVAL_W-1:0] in_interval;
    logic                  accept;
    logic                  out_free;
    logic                  ram_en;
    logic                  ram_we;
    logic [INTERVAL_W-1:0] ram_rdata;
    logic                  cfg_write;

    logic [SUM_W:0]        div_trial;
    logic                  div_ge;
    logic [SUM_W-1:0]      rem_step;
    logic [DIVIDEND_W-1:0] quo_step;

    logic [FPS_W-1:0]      fps_val;
    logic [DELAY_W-1:0]    delay_val;
    logic [DIVIDEND_W-1:0] fps_dividend;

    localparam logic [DIVIDEND_W-1:0] FPS_SCALE = DIVIDEND_W'(FPS_SCALE_VAL);

    assign in_start = s_tdata[31:0];
    assign in_now   = s_tdata[63:32];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_FPS) ? 32'(max_fps_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_fps_reg <= MAXFPS_RESET;
        end else if (cfg_write && paddr[2] == REG_MAX_FPS) begin
            max_fps_reg <= pwdata[MAXFPS_W-1:0];
        end
    end

    // Interval since the previous frame end, saturated
    assign in_diff = in_now - prev_reg;
    always_comb begin
        if (fill_reg == '0) begin
            in_interval = '0;
        end else if (in_diff > TIME_W'(INTERVAL_MAX)) begin
            in_interval = INTERVAL_MAX;
        end else begin
            in_interval = in_diff[INTERVAL_W-1:0];
        end
    end

    // Ring memory: read old entry on accept, write new one in ST_UPD
    assign ram_en = accept || (state_reg == ST_UPD);
    assign ram_we = (state_reg == ST_UPD);

    frml_ram #(
        .WIDTH (INTERVAL_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (slot_reg),
        .wdata (interval_reg),
        .rdata (ram_rdata)
    );

    // One restoring divider step
    assign div_trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dsr_reg});
    assign rem_step  = div_ge ? SUM_W'(div_trial - {1'b0, dsr_reg}) : div_trial[SUM_W-1:0];
    assign quo_step  = {quo_reg[DIVIDEND_W-2:0], div_ge};

    assign fps_dividend = DIVIDEND_W'(fill_reg) * FPS_SCALE;

    // Result fields
    always_comb begin
        if (sum_reg == '0) begin
            fps_val = FPS_WHEN_IDLE;
        end else if (quo_reg > DIVIDEND_W'(FPS_MAX)) begin
            fps_val = FPS_MAX;
        end else begin
            fps_val = FPS_W'(quo_reg);
        end
        if (TIME_W'(period_reg) > duration_reg) begin
            delay_val = period_reg - duration_reg[DELAY_W-1:0];
        end else begin
            delay_val = '0;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_DIVP;
            end
            ST_DIVP: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DIVF;
                end
            end
            ST_DIVF: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: fill count, slot, previous time, sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            slot_reg <= '0;
            prev_reg <= '0;
            sum_reg  <= '0;
        end else begin
            if (accept) begin
                prev_reg <= in_now;
            end
            if (state_reg == ST_UPD) begin
                if (fill_reg >= FILL_W'(WINDOW)) begin
                    sum_reg <= sum_reg - SUM_W'(ram_rdata) + SUM_W'(interval_reg);
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                    sum_reg  <= sum_reg + SUM_W'(interval_reg);
                end
                if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                    slot_reg <= '0;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
        end
    end

    // Divider and per-item payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        interval_reg <= in_interval;
                        duration_reg <= in_now - in_start;
                    end
                end
                ST_UPD: begin
                    // period = 1000 / max(max_fps, 1)
                    rem_reg <= '0;
                    quo_reg <= DIVIDEND_W'(MS_PER_SEC);
                    dsr_reg <= (max_fps_reg == '0) ? SUM_W'(1) : SUM_W'(max_fps_reg);
                    cnt_reg <= DIVCNT_W'(DIVIDEND_W);
                end
                ST_DIVP: begin
                    if (cnt_reg != '0) begin
                        rem_reg <= rem_step;
                        quo_reg <= quo_step;
                        cnt_reg <= cnt_reg - 1'b1;
                    end else begin
                        // rate = 256000 * count / sum
                        period_reg <= quo_reg[DELAY_W-1:0];
                        rem_reg    <= '0;
                        quo_reg    <= fps_dividend;
                        dsr_reg    <= sum_reg;
                        cnt_reg    <= DIVCNT_W'(DIVIDEND_W);
                    end
                end
                ST_DIVF: begin
                    if (cnt_reg != '0) begin
                        rem_reg <= rem_step;
                        quo_reg <= quo_step;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {7'd0, delay_val, fps_val};
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill count above window");

    a_slot_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg < FILL_W'(WINDOW)) |-> (FILL_W'(slot_reg) == fill_reg))
        else $error("slot pointer out of step with fill count");

    a_empty_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> (sum_reg == '0))
        else $error("nonzero sum with empty ring");

    a_accept_to_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_UPD) && !s_tready)
        else $error("accepted transfer did not start an update");

    a_done_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("finished item not loaded into output register");

endmodule

/* hw/rtl/frml_ram.sv */
module frml_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, read data registered
    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule
